[design/pwb_pkg.sv]
`default_nettype none

package pwb_pkg;

    // Field and window geometry
    localparam int SAMPLE_W     = 16;
    localparam int WINDOW_DEPTH = 1024;
    localparam int POS_W        = $clog2(WINDOW_DEPTH);
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = 16;
    localparam int CFG_W        = 16;
    localparam int BYTE_W       = 8;
    localparam int BITPOS_W     = $clog2(BYTE_W);

    // APB port geometry
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register reset values
    localparam logic [CFG_W-1:0] LEVEL_THRESHOLD_RST   = 16'd200;
    localparam logic [CFG_W-1:0] LONG_PULSE_LENGTH_RST = 16'd50;
    localparam logic [CFG_W-1:0] END_GAP_LENGTH_RST    = 16'd1000;
    localparam logic             LETTERS_ONLY_RST      = 1'b1;

    typedef enum logic [1:0] {
        REG_LEVEL_THRESHOLD   = 2'd0,
        REG_LONG_PULSE_LENGTH = 2'd1,
        REG_END_GAP_LENGTH    = 2'd2,
        REG_LETTERS_ONLY      = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        LINE_IDLE  = 2'd0,
        LINE_PULSE = 2'd1,
        LINE_GAP   = 2'd2
    } line_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] level_threshold;
        logic [CFG_W-1:0] long_pulse_length;
        logic [CFG_W-1:0] end_gap_length;
        logic             letters_only;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        line_state_t         line_state;
        logic                byte_valid;
        logic [BYTE_W-1:0]   byte_value;
        logic                message_end;
    } result_t;

endpackage

`default_nettype wire

[design/pwb_ram.sv]
`default_nettype none

module pwb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/pwb_decoder.sv]
`default_nettype none

module pwb_decoder (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             step,
    input  wire logic [pwb_pkg::SAMPLE_W-1:0]     avg,
    input  wire pwb_pkg::cfg_t                    cfg,
    output      pwb_pkg::result_t                 result
);

    localparam logic [pwb_pkg::BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [pwb_pkg::CNT_W-1:0]  CNT_MAX    = '1;
    localparam logic [pwb_pkg::BITPOS_W-1:0] LAST_BIT = '1;

    pwb_pkg::line_state_t                 state_reg,  state_next;
    logic [pwb_pkg::CNT_W-1:0]            pulse_reg,  pulse_next;
    logic [pwb_pkg::CNT_W-1:0]            gap_reg,    gap_next;
    logic [pwb_pkg::BYTE_W-1:0]           byte_reg,   byte_next;
    logic [pwb_pkg::BITPOS_W-1:0]         bitpos_reg, bitpos_next;
    pwb_pkg::result_t                     result_reg, result_next;

    logic                                 level_high;
    logic                                 level_low;
    logic [pwb_pkg::CNT_W-1:0]            pulse_inc;
    logic [pwb_pkg::CNT_W-1:0]            gap_inc;
    logic [pwb_pkg::BYTE_W-1:0]           byte_shift;
    logic                                 is_letter;

    // Classify the level and form saturating counts
    assign level_high = avg > cfg.level_threshold;
    assign level_low  = avg < cfg.level_threshold;
    assign pulse_inc  = (pulse_reg == CNT_MAX) ? CNT_MAX : pulse_reg + 1'b1;
    assign gap_inc    = (gap_reg == CNT_MAX) ? CNT_MAX : gap_reg + 1'b1;
    assign byte_shift = byte_reg
                      | (pwb_pkg::BYTE_W'(pulse_inc > cfg.long_pulse_length) << bitpos_reg);
    assign is_letter  = byte_shift inside {[8'h41:8'h5A], [8'h61:8'h7A]};

    // Next state and result
    always_comb
    begin
        state_next  = state_reg;
        pulse_next  = pulse_reg;
        gap_next    = gap_reg;
        byte_next   = byte_reg;
        bitpos_next = bitpos_reg;

        result_next             = '0;
        result_next.average     = avg;

        case (state_reg)
            pwb_pkg::LINE_PULSE:
            begin
                pulse_next = pulse_inc;
                if (level_low)
                begin
                    state_next = pwb_pkg::LINE_GAP;
                    gap_next   = '0;
                    if (bitpos_reg == LAST_BIT)
                    begin
                        result_next.byte_valid = 1'b1;
                        result_next.byte_value = (cfg.letters_only && !is_letter)
                                               ? CHAR_SPACE : byte_shift;
                        byte_next   = '0;
                        bitpos_next = '0;
                    end
                    else
                    begin
                        byte_next   = byte_shift;
                        bitpos_next = bitpos_reg + 1'b1;
                    end
                end
            end
            pwb_pkg::LINE_GAP:
            begin
                gap_next = gap_inc;
                if (level_high)
                begin
                    state_next = pwb_pkg::LINE_PULSE;
                    pulse_next = '0;
                end
                if (gap_inc > cfg.end_gap_length)
                begin
                    gap_next                = '0;
                    state_next              = pwb_pkg::LINE_IDLE;
                    result_next.message_end = 1'b1;
                end
            end
            default:
            begin
                state_next = pwb_pkg::LINE_IDLE;
                if (level_high)
                begin
                    state_next  = pwb_pkg::LINE_PULSE;
                    pulse_next  = '0;
                    byte_next   = '0;
                    bitpos_next = '0;
                end
            end
        endcase

        result_next.line_state = state_next;
    end

    // Advance decoder state one beat at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pwb_pkg::LINE_IDLE;
            pulse_reg  <= '0;
            gap_reg    <= '0;
            byte_reg   <= '0;
            bitpos_reg <= '0;
            result_reg <= '0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            pulse_reg  <= pulse_next;
            gap_reg    <= gap_next;
            byte_reg   <= byte_next;
            bitpos_reg <= bitpos_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    // A finished byte always leaves the decoder in the gap state
    a_byte_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_reg.byte_valid |-> result_reg.line_state == pwb_pkg::LINE_GAP)
        else $error("byte completed outside gap state");

    // End of message always returns to idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_reg.message_end |-> result_reg.line_state == pwb_pkg::LINE_IDLE)
        else $error("message end without idle");

    // Byte value is zero when no byte was completed
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !result_reg.byte_valid |-> result_reg.byte_value == '0)
        else $error("byte value without byte");

endmodule

`default_nettype wire

[design/pulse_width_bit_receiver.sv]
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_ready  sample
// result    out        result_valid / result_ready  average, line_state, byte_valid,
//                                                   byte_value, message_end
// config    in         APB psel/penable/pready      paddr, pwdata, prdata
//
// One sample beat per cycle unless stalled; results leave via s1, s2 and result regs.
// The 1024 x 16 window ring sits in a single RAM: read at accept, written back when
// that beat leaves the first stage, so the running sum is updated once per beat.
// After reset the ring needs no clearing pass: entries not yet written since reset
// are taken as zero until the write pointer has wrapped once.
// A held result stalls the whole pipeline; sample_ready drops only in that case.
`default_nettype none

module pulse_width_bit_receiver (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         sample_valid,
    output      logic                         sample_ready,
    input  wire logic [15:0]                  sample,

    output      logic                         result_valid,
    input  wire logic                         result_ready,
    output      logic [15:0]                  average,
    output      logic [1:0]                   line_state,
    output      logic                         byte_valid,
    output      logic [7:0]                   byte_value,
    output      logic                         message_end,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pwb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pwb_pkg::PDATA_W-1:0]  pwdata,
    output      logic [pwb_pkg::PDATA_W-1:0]  prdata,
    output      logic                         pready
);

    localparam logic [pwb_pkg::POS_W-1:0]    LAST_POS   =
        pwb_pkg::POS_W'(pwb_pkg::WINDOW_DEPTH - 1);
    localparam logic [pwb_pkg::SUM_W-1:0]    SAMPLE_MAX =
        pwb_pkg::SUM_W'({pwb_pkg::SAMPLE_W{1'b1}});
    localparam logic [pwb_pkg::SUM_W-1:0]    SUM_MAX    =
        pwb_pkg::SUM_W'(pwb_pkg::WINDOW_DEPTH) * SAMPLE_MAX;

    pwb_pkg::cfg_t                   cfg_reg;
    pwb_pkg::reg_index_t             cfg_index;
    logic                            cfg_write;

    logic                            advance;
    logic                            accept;

    logic [pwb_pkg::POS_W-1:0]       wp_reg;
    logic                            filled_reg;

    logic                            s1_valid_reg;
    logic [pwb_pkg::SAMPLE_W-1:0]    s1_sample_reg;
    logic [pwb_pkg::POS_W-1:0]       s1_pos_reg;
    logic                            s1_old_ok_reg;

    logic [pwb_pkg::SUM_W-1:0]       sum_reg;
    logic [pwb_pkg::SUM_W-1:0]       sum_next;
    logic [pwb_pkg::SUM_W-1:0]       avg_full;
    logic [pwb_pkg::SAMPLE_W-1:0]    avg_sat;
    logic [pwb_pkg::SAMPLE_W-1:0]    old_sample;

    logic                            s2_valid_reg;
    logic [pwb_pkg::SAMPLE_W-1:0]    s2_avg_reg;

    logic                            result_valid_reg;
    pwb_pkg::result_t                result;

    logic                            ram_we;
    logic [pwb_pkg::SAMPLE_W-1:0]    ram_rdata;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_index = pwb_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_threshold   <= pwb_pkg::LEVEL_THRESHOLD_RST;
            cfg_reg.long_pulse_length <= pwb_pkg::LONG_PULSE_LENGTH_RST;
            cfg_reg.end_gap_length    <= pwb_pkg::END_GAP_LENGTH_RST;
            cfg_reg.letters_only      <= pwb_pkg::LETTERS_ONLY_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pwb_pkg::REG_LEVEL_THRESHOLD:   cfg_reg.level_threshold   <= pwdata[15:0];
                pwb_pkg::REG_LONG_PULSE_LENGTH: cfg_reg.long_pulse_length <= pwdata[15:0];
                pwb_pkg::REG_END_GAP_LENGTH:    cfg_reg.end_gap_length    <= pwdata[15:0];
                pwb_pkg::REG_LETTERS_ONLY:      cfg_reg.letters_only      <= pwdata[0];
                default:                        ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (cfg_index)
            pwb_pkg::REG_LEVEL_THRESHOLD:   prdata = pwb_pkg::PDATA_W'(cfg_reg.level_threshold);
            pwb_pkg::REG_LONG_PULSE_LENGTH: prdata = pwb_pkg::PDATA_W'(cfg_reg.long_pulse_length);
            pwb_pkg::REG_END_GAP_LENGTH:    prdata = pwb_pkg::PDATA_W'(cfg_reg.end_gap_length);
            pwb_pkg::REG_LETTERS_ONLY:      prdata = pwb_pkg::PDATA_W'(cfg_reg.letters_only);
            default:                        prdata = '0;
        endcase
    end

    // Pipeline moves whenever the result register is free or draining
    assign advance      = !result_valid_reg || result_ready;
    assign sample_ready = advance;
    assign accept       = sample_valid && sample_ready;

    // Window ring
    assign ram_we = advance && s1_valid_reg;

    pwb_ram #(
        .WIDTH (pwb_pkg::SAMPLE_W),
        .DEPTH (pwb_pkg::WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_pos_reg),
        .wdata (s1_sample_reg),
        .re    (accept),
        .raddr (wp_reg),
        .rdata (ram_rdata)
    );

    // Running sum and average
    assign old_sample = s1_old_ok_reg ? ram_rdata : '0;
    assign sum_next   = sum_reg - pwb_pkg::SUM_W'(old_sample) + pwb_pkg::SUM_W'(s1_sample_reg);
    assign avg_full   = sum_next / pwb_pkg::SUM_W'(pwb_pkg::WINDOW_DEPTH);
    assign avg_sat    = (avg_full > SAMPLE_MAX) ? '1 : avg_full[pwb_pkg::SAMPLE_W-1:0];

    // Write pointer and fill flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            filled_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (wp_reg == LAST_POS)
            begin
                wp_reg     <= '0;
                filled_reg <= 1'b1;
            end
            else
            begin
                wp_reg <= wp_reg + 1'b1;
            end
        end
    end

    // Stage valids and the sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            sum_reg          <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg     <= accept;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_pos_reg    <= wp_reg;
            s1_old_ok_reg <= filled_reg;
        end
        if (advance && s1_valid_reg)
        begin
            s2_avg_reg <= avg_sat;
        end
    end

    // Pulse decoder and result register
    pwb_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance && s2_valid_reg),
        .avg    (s2_avg_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign result_valid = result_valid_reg;
    assign average      = result.average;
    assign line_state   = result.line_state;
    assign byte_valid   = result.byte_valid;
    assign byte_value   = result.byte_value;
    assign message_end  = result.message_end;

    // Read and write of the ring never hit the same entry in one cycle
    a_ring_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && accept) |-> (s1_pos_reg != wp_reg))
        else $error("ring read and write collide");

    // Running sum stays within the window bound
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_MAX)
        else $error("window sum out of range");

    // Fill flag rises only on pointer wrap
    a_fill_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(filled_reg) |-> (wp_reg == '0))
        else $error("fill flag set without wrap");

endmodule

`default_nettype wire
